// ----- rtl/ultrasonic_ping_range_controller_assert.svh -----
// Assertion macros used by the checker file of the ranging controller.
`ifndef ULTRASONIC_PING_RANGE_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_PING_RANGE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define UPRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define UPRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uprc_pkg.sv -----
`default_nettype none

package uprc_pkg;

  // Register indexes on the configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_PING_RATE    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_ENABLE = 1'b1;

  // Field widths.
  localparam int RATE_W   = 6;
  localparam int TIME_W   = 32;
  localparam int LINK_W   = 2;
  localparam int RANGE_W  = 14;
  localparam int CFG_W    = RATE_W;
  localparam int IN_DW    = 2 * TIME_W;
  localparam int OUT_DW   = 24;

  // Link status codes.
  localparam logic [LINK_W-1:0] LINK_NONE = 2'd0;
  localparam logic [LINK_W-1:0] LINK_UP   = 2'd1;
  localparam logic [LINK_W-1:0] LINK_LOST = 2'd2;

  // Input kinds carried on tuser.
  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Timing constants in milliseconds.
  localparam logic [TIME_W-1:0] REPLY_TIMEOUT_MS = 32'd500;
  localparam logic [TIME_W-1:0] PING_TIMEOUT     = 32'd100;

  // Range conversion constants.
  localparam logic [RATE_W-1:0]  US_PER_CM     = 6'd58;
  localparam logic [15:0]        RANGE_LO_CM   = 16'd15;
  localparam logic [15:0]        RANGE_HI_CM   = 16'd60;
  localparam logic [RATE_W-1:0]  LOW_LIMIT_CM  = 6'd20;
  localparam logic [RANGE_W-1:0] OUT_LOW_CODE  = 14'd1;
  localparam logic [RANGE_W-1:0] OUT_HIGH_CODE = 14'd9999;

  // The echo width over 58 is half the width over 29. The reciprocal of 29
  // scaled by 2^36 and rounded up gives the exact quotient for any 31-bit
  // half width after a right shift by 36.
  localparam logic [TIME_W-1:0] CM_RECIP = 32'd2369637129;
  localparam int                CM_SHIFT = 36;

  // Ping interval numerator: 1000 ms over pings per second.
  localparam int RATE_NUM   = 1000;
  localparam int RATE_NUM_W = $clog2(RATE_NUM + 1);

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_W      = TIME_W;
  localparam int DIV_STEP_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/uprc_div.sv -----
`default_nettype none

// Restoring serial divider with a narrow divisor. The dividend is taken
// MSB first; after the requested number of steps the quotient sits in the
// low bits of the shift register.
module uprc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire uprc_pkg::div_req_t          req,
  input  wire logic [uprc_pkg::DIV_W-1:0]  dividend,
  input  wire logic [uprc_pkg::RATE_W-1:0] divisor,
  output logic                             done,
  output logic [uprc_pkg::DIV_W-1:0]       quotient
);
  import uprc_pkg::*;

  logic [DIV_STEP_W-1:0] cnt_r;
  logic                  done_r;
  logic [DIV_W-1:0]      quo_r;
  logic [DIV_W-1:0]      quo_nxt;
  logic [RATE_W-1:0]     rem_r;
  logic [RATE_W-1:0]     rem_nxt;
  logic [RATE_W:0]       rem_sh;
  logic                  ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_nxt = ge ? RATE_W'(rem_sh - {1'b0, divisor}) : rem_sh[RATE_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/ultrasonic_ping_range_controller.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata: edge_time_us, now_ms; tuser: cmd
// out_      master     out_tvalid/out_tready tdata: link_status, range_cm,
//                                            range_updated, ping_fire
// cfg_      write only cfg_we               cfg_addr, cfg_wdata
//
// An echo edge word or a disabled update goes from idle to the push state,
// which loads the output register and returns to idle for the next word.
// An enabled update runs the silence check, or the multiply and range steps
// when it consumes an echo, then the divider, two ping checks and the push.
// The echo width over 58 is one registered multiply by a reciprocal, and the
// one-bit-per-cycle divider runs 10 steps for ping interval 1000 over ping_rate.
// Synchronous reset on rst_n low clears ranging state, not scratch or out_tdata.
// in_tready is high only while the sequencer is idle; a result waits in the
// output register while the next word is accepted, and the sequencer stalls
// with the following result until out_tready takes the waiting one.
module ultrasonic_ping_range_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [uprc_pkg::IN_DW-1:0]      in_tdata,  // edge_time_us, now_ms
  input  wire logic                            in_tuser,  // cmd
  // Result channel.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // link_status, range_cm, range_updated, ping_fire, zero fill
  output logic [uprc_pkg::OUT_DW-1:0]          out_tdata,
  // Configuration port.
  input  wire logic                            cfg_we,
  input  wire logic [uprc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [uprc_pkg::CFG_W-1:0]      cfg_wdata
);
  import uprc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TMO,
    S_WMUL,
    S_RNG,
    S_RSTART,
    S_RDIV,
    S_PC1,
    S_PC2,
    S_PUSH
  } state_t;

  localparam logic [DIV_W-1:0] RATE_DIVIDEND =
    DIV_W'(RATE_NUM) << (DIV_W - RATE_NUM_W);

  state_t              state_r;
  logic [RATE_W-1:0]   ping_rate_r;
  logic                range_en_r;
  logic                echo_high_r;
  logic                echo_pending_r;
  logic [TIME_W-1:0]   rise_r;
  logic [TIME_W-1:0]   fall_r;
  logic [TIME_W-1:0]   last_ping_r;
  logic [TIME_W-1:0]   last_reply_r;
  logic [LINK_W-1:0]   link_r;
  logic [RATE_W-1:0]   prior_r;
  logic [RANGE_W-1:0]  held_r;
  logic                upd_r;
  logic                fire_r;
  logic                out_tvalid_r;
  logic [OUT_DW-1:0]   out_tdata_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   width_r;
  logic                late_r;
  logic [15:0]         cm16_r;

  logic [TIME_W-1:0]   in_edge;
  logic [TIME_W-1:0]   in_now;
  logic                in_fire;
  logic                enabled;
  logic                out_free;

  div_req_t            div_req;
  logic [DIV_W-1:0]    div_dividend;
  logic [RATE_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;
  logic [2*TIME_W-2:0] cm_prod;
  logic                cm_ok;

  assign in_edge   = in_tdata[TIME_W-1:0];
  assign in_now    = in_tdata[IN_DW-1:TIME_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign enabled   = (ping_rate_r != '0) && range_en_r;
  assign out_free  = !out_tvalid_r || out_tready;

  // Divider request: 1000 over the ping rate.
  always_comb begin
    div_req.start = (state_r == S_RSTART);
    div_req.steps = DIV_STEP_W'(RATE_NUM_W);
  end

  assign div_dividend = RATE_DIVIDEND;
  assign div_divisor  = ping_rate_r;

  uprc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Echo width over 58: the half width times the scaled reciprocal of 29,
  // a 31 by 32 bit product.
  assign cm_prod = (2*TIME_W-1)'(width_r[TIME_W-1:1]) * (2*TIME_W-1)'(CM_RECIP);

  // Range test on the truncated quotient.
  assign cm_ok = (cm16_r >= RANGE_LO_CM) && (cm16_r <= RANGE_HI_CM);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_rate_r <= RATE_W'(10);
      range_en_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PING_RATE:    ping_rate_r <= cfg_wdata;
        REG_RANGE_ENABLE: range_en_r  <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Sequencer, ranging state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      echo_high_r    <= 1'b0;
      echo_pending_r <= 1'b0;
      rise_r         <= '0;
      fall_r         <= '0;
      last_ping_r    <= '0;
      last_reply_r   <= '0;
      link_r         <= LINK_NONE;
      prior_r        <= '0;
      held_r         <= '0;
      upd_r          <= 1'b0;
      fire_r         <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_PUSH) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            upd_r  <= 1'b0;
            fire_r <= 1'b0;
            now_r  <= in_now;
            width_r <= fall_r - rise_r;
            if (in_tuser == CMD_EDGE) begin
              // Edges alternate between rise and fall.
              echo_high_r <= !echo_high_r;
              if (!echo_high_r) begin
                rise_r <= in_edge;
              end else begin
                fall_r         <= in_edge;
                echo_pending_r <= 1'b1;
              end
              state_r <= S_PUSH;
            end else if (!enabled) begin
              link_r  <= LINK_NONE;
              held_r  <= '0;
              state_r <= S_PUSH;
            end else if (echo_pending_r) begin
              state_r <= S_WMUL;
            end else begin
              state_r <= S_TMO;
            end
          end
        end
        S_TMO: begin
          // Silence check against the last reply.
          if (link_r == LINK_UP && now_r > last_reply_r + REPLY_TIMEOUT_MS) begin
            link_r <= LINK_LOST;
          end
          state_r <= S_RSTART;
        end
        S_WMUL: begin
          // Keep the low 16 bits of the quotient.
          cm16_r  <= cm_prod[CM_SHIFT+15:CM_SHIFT];
          state_r <= S_RNG;
        end
        S_RNG: begin
          // Consume the echo and map out-of-window readings.
          link_r         <= LINK_UP;
          echo_pending_r <= 1'b0;
          upd_r          <= 1'b1;
          last_reply_r   <= now_r;
          if (cm_ok) begin
            prior_r <= cm16_r[RATE_W-1:0];
            held_r  <= RANGE_W'(cm16_r);
          end else if (prior_r < LOW_LIMIT_CM) begin
            held_r <= OUT_LOW_CODE;
          end else begin
            held_r <= OUT_HIGH_CODE;
          end
          state_r <= S_RSTART;
        end
        S_RSTART: state_r <= S_RDIV;
        S_RDIV: begin
          if (div_done) begin
            state_r <= S_PC1;
          end
        end
        S_PC1: begin
          late_r  <= now_r > last_ping_r + div_q;
          state_r <= S_PC2;
        end
        S_PC2: begin
          if (late_r && (last_reply_r >= last_ping_r ||
                         now_r > last_ping_r + PING_TIMEOUT)) begin
            fire_r      <= 1'b1;
            last_ping_r <= now_r;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{(OUT_DW - LINK_W - RANGE_W - 2){1'b0}},
                             fire_r, upd_r, held_r, link_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- rtl/uprc_check.sv -----
`default_nettype none

`include "ultrasonic_ping_range_controller_assert.svh"

// Port-level checks on the result channel of the ranging controller.
module uprc_check (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [uprc_pkg::OUT_DW-1:0] out_tdata
);
  import uprc_pkg::*;

  logic [LINK_W-1:0]  link;
  logic [RANGE_W-1:0] range;
  logic               updated;

  assign link    = out_tdata[LINK_W-1:0];
  assign range   = out_tdata[LINK_W+RANGE_W-1:LINK_W];
  assign updated = out_tdata[LINK_W+RANGE_W];

  // A stalled word keeps its payload.
  `UPRC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  // Range codes never exceed the high code.
  `UPRC_ASSERT_NOW(a_range_max, out_tvalid, range <= OUT_HIGH_CODE, "range above high code")
  // A fresh echo always means a live link and a nonzero range.
  `UPRC_ASSERT_NOW(a_upd_link, out_tvalid && updated, link == LINK_UP && range != '0, "update without live link")
  // No link means no held range.
  `UPRC_ASSERT_NOW(a_none_zero, out_tvalid && link == LINK_NONE, range == '0, "range held while not connected")

endmodule

bind ultrasonic_ping_range_controller uprc_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
